// ----- hw/rtl/utf8d_pkg.sv -----
package utf8d_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CP_W   = 21;
  localparam int unsigned CNT_W  = 3;
  localparam int unsigned OUT_W  = CP_W + CNT_W;

  // sequence lengths as held in bytes_expected / emitted as byte_count
  localparam logic [CNT_W-1:0] LEN_NONE = 3'd0;
  localparam logic [CNT_W-1:0] LEN_1    = 3'd1;
  localparam logic [CNT_W-1:0] LEN_2    = 3'd2;
  localparam logic [CNT_W-1:0] LEN_3    = 3'd3;
  localparam logic [CNT_W-1:0] LEN_4    = 3'd4;

  // smallest legal value for each length, top of range, surrogate window
  localparam logic [CP_W-1:0] CP_MIN_2   = 21'h00080;
  localparam logic [CP_W-1:0] CP_MIN_3   = 21'h00800;
  localparam logic [CP_W-1:0] CP_MIN_4   = 21'h10000;
  localparam logic [CP_W-1:0] CP_MAX     = 21'h10FFFF;
  localparam logic [CP_W-1:0] CP_SURR_LO = 21'h0D800;
  localparam logic [CP_W-1:0] CP_SURR_HI = 21'h0DFFF;

  typedef struct packed {
    logic [CP_W-1:0]  partial_value;
    logic [CNT_W-1:0] bytes_expected;
    logic [CNT_W-1:0] bytes_seen;
  } seq_state_t;

  typedef struct packed {
    logic             valid;
    logic [CP_W-1:0]  code_point;
    logic [CNT_W-1:0] byte_count;
    logic             end_of_text;
  } dec_result_t;

  localparam seq_state_t SEQ_IDLE = '{partial_value: '0, bytes_expected: LEN_NONE,
                                      bytes_seen: '0};

endpackage

// ----- hw/rtl/utf8_decoder_skip_malformed_core.sv -----
// A byte accepted into the input register is decoded and its result loaded into the result register, which drives out_.
// Throughput: one byte per cycle; in_tready drops only when the input register
// is full and the result register holds an item not taken this cycle.
// Bytes that close no valid character produce no item.
// Reset (rst_n low, synchronous): both registers empty, no sequence open.
module utf8_decoder_skip_malformed_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [utf8d_pkg::BYTE_W-1:0] in_tdata,   // text_byte[7:0]
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [utf8d_pkg::OUT_W-1:0]  out_tdata,  // code_point[20:0], byte_count[23:21]
  output logic                         out_tlast   // end_of_text
);
  import utf8d_pkg::*;

  // input register
  logic              s1_valid_r, s1_valid_nxt;
  logic [BYTE_W-1:0] s1_byte_r;

  // open-sequence state; updated as the byte in the input register retires
  seq_state_t  state_r, state_nxt;
  seq_state_t  step_state;
  dec_result_t step_result;

  logic out_free;
  logic s1_adv;   // input register hands its byte to the decode step
  logic in_acc;

  assign s1_adv    = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end
    state_nxt = s1_adv ? step_state : state_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      state_r    <= SEQ_IDLE;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      state_r    <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r <= in_tdata;
    end
  end

  utf8d_step u_step (
    .byte_i   (s1_byte_r),
    .state_i  (state_r),
    .state_o  (step_state),
    .result_o (step_result)
  );

  utf8d_outbuf u_outbuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_i     (s1_adv && step_result.valid),
    .result_i   (step_result),
    .free_o     (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // an open sequence always has its lead counted and is short of its length
  a_seen_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.bytes_expected != LEN_NONE) |->
      (state_r.bytes_seen != '0 && state_r.bytes_seen < state_r.bytes_expected))
    else $error("bytes_seen out of range for open sequence");

  // no open sequence means fully cleared state
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.bytes_expected == LEN_NONE) |->
      (state_r.bytes_seen == '0 && state_r.partial_value == '0))
    else $error("stale sequence state while idle");

  // end marker carries zero value and count
  a_eot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> (out_tdata == '0))
    else $error("end marker with nonzero payload");

  // characters are legal scalar values with a real length
  a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tlast) |->
      (out_tdata[OUT_W-1:CP_W] != LEN_NONE && out_tdata[CP_W-1:0] <= CP_MAX &&
       (out_tdata[CP_W-1:0] < CP_SURR_LO || out_tdata[CP_W-1:0] > CP_SURR_HI)))
    else $error("illegal character on output");

  // input stalls only while both registers are full and the result is not taken
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid_r && out_tvalid && !out_tready))
    else $error("input stalled without backpressure");

endmodule

// ----- hw/rtl/utf8d_step.sv -----
// One byte of decode: sequence state plus byte in, next state and result out.
module utf8d_step (
  input  logic [utf8d_pkg::BYTE_W-1:0] byte_i,
  input  utf8d_pkg::seq_state_t        state_i,
  output utf8d_pkg::seq_state_t        state_o,
  output utf8d_pkg::dec_result_t       result_o
);
  import utf8d_pkg::*;

  logic             is_cont;
  logic             fresh;
  logic             bad;
  logic [CP_W-1:0]  cp;
  logic [CNT_W-1:0] seen_inc;

  assign is_cont  = (byte_i[7:6] == 2'b10);
  assign cp       = {state_i.partial_value[CP_W-7:0], byte_i[5:0]};
  assign seen_inc = state_i.bytes_seen + LEN_1;

  always_comb begin
    bad = (cp inside {[CP_SURR_LO:CP_SURR_HI]});
    case (state_i.bytes_expected)
      LEN_2:   bad = bad || (cp < CP_MIN_2);
      LEN_3:   bad = bad || (cp < CP_MIN_3);
      LEN_4:   bad = bad || (cp < CP_MIN_4) || (cp > CP_MAX);
      default: bad = 1'b1;
    endcase
  end

  always_comb begin
    state_o  = state_i;
    result_o = '0;
    fresh    = 1'b1;

    if (state_i.bytes_expected != LEN_NONE) begin
      state_o = SEQ_IDLE;
      if (is_cont) begin
        fresh = 1'b0;
        if (seen_inc < state_i.bytes_expected) begin
          state_o               = state_i;
          state_o.partial_value = cp;
          state_o.bytes_seen    = seen_inc;
        end else if (!bad) begin
          result_o.valid      = 1'b1;
          result_o.code_point = cp;
          result_o.byte_count = state_i.bytes_expected;
        end
      end
      // a breaking byte falls through and is decoded afresh
    end

    if (fresh) begin
      if (byte_i == '0) begin
        result_o.valid       = 1'b1;
        result_o.end_of_text = 1'b1;
      end else if (byte_i inside {[8'h01:8'h7F]}) begin
        result_o.valid      = 1'b1;
        result_o.code_point = {{(CP_W-BYTE_W){1'b0}}, byte_i};
        result_o.byte_count = LEN_1;
      end else if (byte_i[7:5] == 3'b110) begin
        if (byte_i[4:0] != 5'd0) begin
          state_o.partial_value  = {{(CP_W-5){1'b0}}, byte_i[4:0]};
          state_o.bytes_expected = LEN_2;
          state_o.bytes_seen     = LEN_1;
        end
      end else if (byte_i[7:4] == 4'b1110) begin
        state_o.partial_value  = {{(CP_W-4){1'b0}}, byte_i[3:0]};
        state_o.bytes_expected = LEN_3;
        state_o.bytes_seen     = LEN_1;
      end else if (byte_i[7:3] == 5'b11110) begin
        state_o.partial_value  = {{(CP_W-3){1'b0}}, byte_i[2:0]};
        state_o.bytes_expected = LEN_4;
        state_o.bytes_seen     = LEN_1;
      end
      // stray continuation, 0xC0 and 0xF8..0xFF: skipped
    end
  end

endmodule

// ----- hw/rtl/utf8d_outbuf.sv -----
// Result register facing the master side.
module utf8d_outbuf (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           load_i,
  input  utf8d_pkg::dec_result_t         result_i,
  output logic                           free_o,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [utf8d_pkg::OUT_W-1:0]    out_tdata,  // code_point[20:0], byte_count[23:21]
  output logic                           out_tlast   // end_of_text
);
  import utf8d_pkg::*;

  logic             valid_r, valid_nxt;
  logic [CP_W-1:0]  cp_r;
  logic [CNT_W-1:0] cnt_r;
  logic             last_r;

  assign free_o = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (out_tready) begin
      valid_nxt = 1'b0;
    end
    if (load_i) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_i) begin
      cp_r   <= result_i.code_point;
      cnt_r  <= result_i.byte_count;
      last_r <= result_i.end_of_text;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {cnt_r, cp_r};
  assign out_tlast  = last_r;

endmodule
